>>> sv/tkat_pkg.sv
// Shared codes, widths and transaction types for the keyword trie automaton.
package tkat_pkg;

  // Field widths fixed by the port list
  localparam int CMD_W       = 2;
  localparam int KEY_W       = 8;
  localparam int KWID_W      = 16;
  localparam int STATE_W     = 12;
  localparam int STATUS_W    = 2;
  localparam int MATCH_ID_W  = 16;
  localparam int CHILD_CNT_W = 9;

  // Parameter defaults
  localparam int NODE_COUNT_DEF = 4096;
  localparam int ID_WIDTH_DEF   = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_PHASE     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key_byte;
    logic               last_byte;
    logic [KWID_W-1:0]  keyword_id;
    logic [STATE_W-1:0] state_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  found;
    logic [MATCH_ID_W-1:0] match_id;
    logic [STATE_W-1:0]    next_state;
    logic [STATE_W-1:0]    fail_state;
  } rsp_t;

endpackage

>>> sv/tkat_engine.sv
// Node memory, breadth-first queue and the command sequencer of the trie automaton.
module tkat_engine #(
  parameter int NODE_COUNT = tkat_pkg::NODE_COUNT_DEF,
  parameter int ID_WIDTH   = tkat_pkg::ID_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tkat_pkg::req_t req,
  output logic           idle,
  output logic           rsp_valid,
  input  logic           rsp_take,
  output tkat_pkg::rsp_t rsp
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = IDX_W + 1;
  localparam int AW    = $clog2(2 * NODE_COUNT);
  localparam int CC_W  = tkat_pkg::CHILD_CNT_W;
  localparam int MID_W = tkat_pkg::MATCH_ID_W;
  localparam int ST_W  = tkat_pkg::STATE_W;

  typedef struct packed {
    logic                vld;
    logic [ID_WIDTH-1:0] id;
    logic [IDX_W-1:0]    fail;
    logic [CC_W-1:0]     cnt;
    logic [IDX_W-1:0]    ns;
    logic [IDX_W-1:0]    fc;
    logic [7:0]          key;
  } node_t;

  typedef struct packed {
    logic             hn;
    logic [IDX_W-1:0] idx;
  } qent_t;

  // Sequencer states
  localparam logic [4:0] ST_INIT   = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_WCUR   = 5'd2;
  localparam logic [4:0] ST_WCHILD = 5'd3;
  localparam logic [4:0] ST_WEND   = 5'd4;
  localparam logic [4:0] ST_IW1    = 5'd5;
  localparam logic [4:0] ST_IW2    = 5'd6;
  localparam logic [4:0] ST_GBASE  = 5'd7;
  localparam logic [4:0] ST_GMID   = 5'd8;
  localparam logic [4:0] ST_GCMP   = 5'd9;
  localparam logic [4:0] ST_GRET   = 5'd10;
  localparam logic [4:0] ST_BSTART = 5'd11;
  localparam logic [4:0] ST_BQRD   = 5'd12;
  localparam logic [4:0] ST_BQWAIT = 5'd13;
  localparam logic [4:0] ST_BNODE  = 5'd14;
  localparam logic [4:0] ST_BCHILD = 5'd15;
  localparam logic [4:0] ST_BFLIP  = 5'd16;
  localparam logic [4:0] ST_FK     = 5'd17;
  localparam logic [4:0] ST_FKRD   = 5'd18;
  localparam logic [4:0] ST_FJ     = 5'd19;
  localparam logic [4:0] ST_FPRD   = 5'd20;
  localparam logic [4:0] ST_FFIN   = 5'd21;
  localparam logic [4:0] ST_RESP   = 5'd22;

  // Memories: two node banks (live and rebuild target) and the BFS queue
  node_t node_mem [2*NODE_COUNT];
  qent_t q_mem [NODE_COUNT];

  node_t nd_rd;
  qent_t q_rd;

  logic             nd_we;
  logic             nd_walt;
  logic [IDX_W-1:0] nd_widx;
  node_t            nd_wdata;
  logic [IDX_W-1:0] nd_ridx;
  logic [AW-1:0]    nd_waddr;
  logic [AW-1:0]    nd_raddr;
  logic             q_we;
  logic [IDX_W-1:0] q_widx;
  qent_t            q_wdata;
  logic [IDX_W-1:0] q_ridx;

  // Control state
  logic [4:0]       state;
  logic             bank;
  logic             built;
  logic [CNT_W-1:0] used;
  logic [IDX_W-1:0] ins_cur;
  logic [IDX_W-1:0] s_cur;
  logic             s_miss;
  logic             gctx;

  // Working registers
  tkat_pkg::req_t   req_q;
  node_t            ent_a;
  node_t            ent_b;
  node_t            ent_p;
  logic [IDX_W-1:0] base_idx;
  logic [IDX_W-1:0] prev_idx;
  logic [IDX_W-1:0] c_idx;
  logic [IDX_W-1:0] new_idx;
  logic [IDX_W-1:0] p_idx;
  logic [IDX_W-1:0] gf;
  logic [IDX_W-1:0] fail_f;
  logic [IDX_W-1:0] gm;
  logic [IDX_W-1:0] mid_idx;
  logic [7:0]       gkey;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] tail;
  logic [CNT_W-1:0] k;
  logic [CC_W-1:0]  j;
  logic             hn;

  logic             hit;
  logic             is_full;
  logic [CNT_W:0]   lohi_sum;
  logic [CNT_W-1:0] mid_w;
  logic [IDX_W-1:0] p_calc;
  logic [CNT_W-1:0] p_ext;
  logic [ID_WIDTH-1:0] req_id;

  assign hit      = (c_idx != '0) && (ent_b.key == req_q.key_byte);
  assign is_full  = used >= CNT_W'(NODE_COUNT);
  assign lohi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_w    = lohi_sum[CNT_W:1];
  assign p_calc   = ent_a.fc + IDX_W'(j);
  assign p_ext    = CNT_W'(ent_a.fc) + CNT_W'(j);
  assign req_id   = ID_WIDTH'(req_q.keyword_id);

  assign idle      = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESP);

  assign nd_waddr = (((nd_walt ? ~bank : bank)) ? AW'(NODE_COUNT) : AW'(0)) + AW'(nd_widx);
  assign nd_raddr = (bank ? AW'(NODE_COUNT) : AW'(0)) + AW'(nd_ridx);

  // Node memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (nd_we) begin
      node_mem[nd_waddr] <= nd_wdata;
    end
    nd_rd <= node_mem[nd_raddr];
  end

  // Queue memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_widx] <= q_wdata;
    end
    q_rd <= q_mem[q_ridx];
  end

  // Drive memory addresses and write data for the current step
  always_comb begin
    nd_we    = 1'b0;
    nd_walt  = 1'b0;
    nd_widx  = '0;
    nd_wdata = '0;
    nd_ridx  = '0;
    q_we     = 1'b0;
    q_widx   = '0;
    q_wdata  = '0;
    q_ridx   = '0;
    case (state)
      ST_INIT: begin
        nd_we = 1'b1;
      end
      ST_IDLE: begin
        case (req.cmd)
          tkat_pkg::CMD_INSERT: nd_ridx = ins_cur;
          tkat_pkg::CMD_SEARCH: nd_ridx = s_cur;
          tkat_pkg::CMD_STEP:   nd_ridx = IDX_W'(req.state_in);
          default:              nd_ridx = '0;
        endcase
      end
      ST_WCUR: begin
        nd_ridx = nd_rd.fc;
      end
      ST_WCHILD: begin
        nd_ridx = nd_rd.ns;
      end
      ST_WEND: begin
        if (req_q.cmd == tkat_pkg::CMD_INSERT) begin
          if (hit) begin
            if (req_q.last_byte) begin
              nd_we        = 1'b1;
              nd_widx      = c_idx;
              nd_wdata     = ent_b;
              nd_wdata.vld = 1'b1;
              nd_wdata.id  = req_id;
            end
          end else if (!is_full) begin
            nd_we        = 1'b1;
            nd_widx      = used[IDX_W-1:0];
            nd_wdata.key = req_q.key_byte;
            nd_wdata.ns  = c_idx;
            nd_wdata.vld = req_q.last_byte;
            nd_wdata.id  = req_q.last_byte ? req_id : '0;
          end
        end
      end
      ST_IW1: begin
        nd_we        = 1'b1;
        nd_widx      = base_idx;
        nd_wdata     = ent_a;
        nd_wdata.cnt = ent_a.cnt + 1'b1;
        nd_wdata.fc  = (prev_idx == '0) ? new_idx : ent_a.fc;
      end
      ST_IW2: begin
        nd_we       = 1'b1;
        nd_widx     = prev_idx;
        nd_wdata    = ent_p;
        nd_wdata.ns = new_idx;
      end
      ST_GMID: begin
        nd_ridx = mid_w[IDX_W-1:0];
      end
      ST_GRET: begin
        if (gctx) begin
          if (gm == '0 && gf != '0) begin
            nd_ridx = fail_f;
          end else begin
            nd_we         = 1'b1;
            nd_widx       = p_idx;
            nd_wdata      = ent_p;
            nd_wdata.fail = gm;
          end
        end
      end
      ST_BSTART: begin
        q_we = 1'b1;
      end
      ST_BQRD: begin
        q_ridx = head[IDX_W-1:0];
      end
      ST_BQWAIT: begin
        nd_ridx = q_rd.idx;
      end
      ST_BNODE: begin
        nd_we        = 1'b1;
        nd_walt      = 1'b1;
        nd_widx      = head[IDX_W-1:0];
        nd_wdata.key = nd_rd.key;
        nd_wdata.fc  = (nd_rd.fc != '0) ? tail[IDX_W-1:0] : '0;
        nd_wdata.ns  = hn ? IDX_W'(head + CNT_W'(1)) : '0;
        nd_wdata.cnt = nd_rd.cnt;
        nd_wdata.vld = nd_rd.vld;
        nd_wdata.id  = nd_rd.id;
        nd_ridx      = nd_rd.fc;
      end
      ST_BCHILD: begin
        if (tail < used) begin
          q_we        = 1'b1;
          q_widx      = tail[IDX_W-1:0];
          q_wdata.hn  = (nd_rd.ns != '0);
          q_wdata.idx = c_idx;
        end
        nd_ridx = nd_rd.ns;
      end
      ST_FK: begin
        nd_ridx = k[IDX_W-1:0];
      end
      ST_FJ: begin
        nd_ridx = p_calc;
      end
      ST_FPRD: begin
        nd_ridx = ent_a.fail;
      end
      default: begin
        nd_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      bank    <= 1'b0;
      built   <= 1'b0;
      used    <= CNT_W'(1);
      ins_cur <= '0;
      s_cur   <= '0;
      s_miss  <= 1'b0;
      gctx    <= 1'b0;
    end else begin
      case (state)
        ST_INIT: begin
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            req_q <= req;
            rsp   <= '0;
            case (req.cmd)
              tkat_pkg::CMD_INSERT: begin
                if (built) begin
                  rsp.status <= tkat_pkg::STATUS_PHASE;
                  state      <= ST_RESP;
                end else begin
                  base_idx <= ins_cur;
                  state    <= ST_WCUR;
                end
              end
              tkat_pkg::CMD_SEARCH: begin
                if (s_miss) begin
                  rsp.status <= tkat_pkg::STATUS_NOT_FOUND;
                  if (req.last_byte) begin
                    s_miss <= 1'b0;
                    s_cur  <= '0;
                  end
                  state <= ST_RESP;
                end else begin
                  base_idx <= s_cur;
                  state    <= ST_WCUR;
                end
              end
              tkat_pkg::CMD_BUILD: begin
                state <= ST_BSTART;
              end
              default: begin
                if (!built) begin
                  rsp.status <= tkat_pkg::STATUS_PHASE;
                  state      <= ST_RESP;
                end else if (32'(req.state_in) >= 32'(used)) begin
                  rsp.status <= tkat_pkg::STATUS_NOT_FOUND;
                  state      <= ST_RESP;
                end else begin
                  gctx  <= 1'b0;
                  gkey  <= req.key_byte;
                  state <= ST_GBASE;
                end
              end
            endcase
          end
        end
        // Walk the sorted child list
        ST_WCUR: begin
          ent_a    <= nd_rd;
          prev_idx <= '0;
          c_idx    <= nd_rd.fc;
          state    <= (nd_rd.fc == '0) ? ST_WEND : ST_WCHILD;
        end
        ST_WCHILD: begin
          ent_b <= nd_rd;
          if (nd_rd.key < req_q.key_byte) begin
            prev_idx <= c_idx;
            ent_p    <= nd_rd;
            c_idx    <= nd_rd.ns;
            state    <= (nd_rd.ns == '0) ? ST_WEND : ST_WCHILD;
          end else begin
            state <= ST_WEND;
          end
        end
        ST_WEND: begin
          state <= ST_RESP;
          if (req_q.cmd == tkat_pkg::CMD_INSERT) begin
            if (hit) begin
              if (req_q.last_byte) begin
                ins_cur      <= '0;
                rsp.match_id <= MID_W'(req_id);
              end else begin
                ins_cur      <= c_idx;
                rsp.match_id <= MID_W'(ent_b.id);
              end
            end else if (is_full) begin
              rsp.status <= tkat_pkg::STATUS_POOL_FULL;
              ins_cur    <= '0;
            end else begin
              new_idx      <= used[IDX_W-1:0];
              used         <= used + CNT_W'(1);
              ins_cur      <= req_q.last_byte ? '0 : used[IDX_W-1:0];
              rsp.match_id <= req_q.last_byte ? MID_W'(req_id) : '0;
              state        <= ST_IW1;
            end
          end else begin
            if (req_q.last_byte) begin
              if (hit && ent_b.vld) begin
                rsp.found    <= 1'b1;
                rsp.match_id <= MID_W'(ent_b.id);
              end else begin
                rsp.status <= tkat_pkg::STATUS_NOT_FOUND;
              end
              s_cur  <= '0;
              s_miss <= 1'b0;
            end else if (hit) begin
              s_cur <= c_idx;
            end else begin
              rsp.status <= tkat_pkg::STATUS_NOT_FOUND;
              s_cur      <= '0;
              s_miss     <= 1'b1;
            end
          end
        end
        ST_IW1: begin
          state <= (prev_idx != '0) ? ST_IW2 : ST_RESP;
        end
        ST_IW2: begin
          state <= ST_RESP;
        end
        // Binary search over a node's contiguous children
        ST_GBASE: begin
          fail_f <= nd_rd.fail;
          lo     <= CNT_W'(nd_rd.fc);
          hi     <= CNT_W'(nd_rd.fc) + CNT_W'(nd_rd.cnt);
          if (nd_rd.cnt == '0) begin
            gm    <= '0;
            state <= ST_GRET;
          end else begin
            state <= ST_GMID;
          end
        end
        ST_GMID: begin
          if (lo < hi) begin
            mid_idx <= mid_w[IDX_W-1:0];
            state   <= ST_GCMP;
          end else begin
            gm    <= '0;
            state <= ST_GRET;
          end
        end
        ST_GCMP: begin
          ent_b <= nd_rd;
          if (nd_rd.key == gkey) begin
            gm    <= mid_idx;
            state <= ST_GRET;
          end else if (nd_rd.key < gkey) begin
            lo    <= CNT_W'(mid_idx) + CNT_W'(1);
            state <= ST_GMID;
          end else begin
            hi    <= CNT_W'(mid_idx);
            state <= ST_GMID;
          end
        end
        ST_GRET: begin
          if (!gctx) begin
            if (gm == '0) begin
              rsp.status <= tkat_pkg::STATUS_NOT_FOUND;
            end else begin
              rsp.next_state <= ST_W'(gm);
              rsp.fail_state <= ST_W'(ent_b.fail);
              rsp.found      <= ent_b.vld;
              rsp.match_id   <= ent_b.vld ? MID_W'(ent_b.id) : '0;
            end
            state <= ST_RESP;
          end else if (gm == '0 && gf != '0) begin
            gf    <= fail_f;
            state <= ST_GBASE;
          end else begin
            j     <= j + 1'b1;
            state <= ST_FJ;
          end
        end
        // Breadth-first renumbering into the other bank
        ST_BSTART: begin
          head  <= '0;
          tail  <= CNT_W'(1);
          state <= ST_BQRD;
        end
        ST_BQRD: begin
          state <= (head == tail) ? ST_BFLIP : ST_BQWAIT;
        end
        ST_BQWAIT: begin
          hn    <= q_rd.hn;
          state <= ST_BNODE;
        end
        ST_BNODE: begin
          c_idx <= nd_rd.fc;
          if (nd_rd.fc != '0) begin
            state <= ST_BCHILD;
          end else begin
            head  <= head + CNT_W'(1);
            state <= ST_BQRD;
          end
        end
        ST_BCHILD: begin
          if (tail < used && nd_rd.ns != '0) begin
            tail  <= tail + CNT_W'(1);
            c_idx <= nd_rd.ns;
          end else begin
            if (tail < used) begin
              tail <= tail + CNT_W'(1);
            end
            head  <= head + CNT_W'(1);
            state <= ST_BQRD;
          end
        end
        ST_BFLIP: begin
          bank  <= ~bank;
          k     <= CNT_W'(1);
          state <= ST_FK;
        end
        // Failure links in breadth-first order
        ST_FK: begin
          state <= (k >= tail) ? ST_FFIN : ST_FKRD;
        end
        ST_FKRD: begin
          ent_a <= nd_rd;
          j     <= '0;
          state <= ST_FJ;
        end
        ST_FJ: begin
          if (j < ent_a.cnt && p_ext < tail) begin
            p_idx <= p_calc;
            state <= ST_FPRD;
          end else begin
            k     <= k + CNT_W'(1);
            state <= ST_FK;
          end
        end
        ST_FPRD: begin
          ent_p <= nd_rd;
          gkey  <= nd_rd.key;
          gf    <= ent_a.fail;
          gctx  <= 1'b1;
          state <= ST_GBASE;
        end
        ST_FFIN: begin
          ins_cur <= '0;
          s_cur   <= '0;
          s_miss  <= 1'b0;
          built   <= 1'b1;
          state   <= ST_RESP;
        end
        ST_RESP: begin
          if (rsp_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/trie_keyword_automaton_table.sv
// Top level of the keyword trie automaton: handshake and result register.
//
//  channel  | handshake                  | fields
//  ---------+----------------------------+-----------------------------------------------
//  item     | item_valid / item_stall    | cmd, key_byte, last_byte, keyword_id, state_in
//  result   | result_valid / result_stall| status, found, match_id, next_state, fail_state
//
// One item at a time through a node memory with one write and one registered read port.
// Insert and search walk the sorted sibling list; a new node also updates its parent and
// any preceding sibling. Step runs a binary search over the node's children. Build
// renumbers the nodes breadth-first into the other bank, then sets the failure links
// with binary searches along each failure chain.
// After reset the root is initialized first; a held result stalls the next item.
module trie_keyword_automaton_table #(
  parameter int NODE_COUNT = tkat_pkg::NODE_COUNT_DEF,
  parameter int ID_WIDTH   = tkat_pkg::ID_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [tkat_pkg::CMD_W-1:0]        cmd,
  input  logic [tkat_pkg::KEY_W-1:0]        key_byte,
  input  logic                              last_byte,
  input  logic [tkat_pkg::KWID_W-1:0]       keyword_id,
  input  logic [tkat_pkg::STATE_W-1:0]      state_in,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [tkat_pkg::STATUS_W-1:0]     status,
  output logic                              found,
  output logic [tkat_pkg::MATCH_ID_W-1:0]   match_id,
  output logic [tkat_pkg::STATE_W-1:0]      next_state,
  output logic [tkat_pkg::STATE_W-1:0]      fail_state
);

  tkat_pkg::req_t req;
  tkat_pkg::rsp_t rsp;
  logic           eng_idle;
  logic           rsp_valid;
  logic           rsp_take;
  logic           start;

  assign req.cmd        = cmd;
  assign req.key_byte   = key_byte;
  assign req.last_byte  = last_byte;
  assign req.keyword_id = keyword_id;
  assign req.state_in   = state_in;

  assign item_stall = !eng_idle;
  assign start      = item_valid && !item_stall;
  assign rsp_take   = !result_valid || !result_stall;

  tkat_engine #(
    .NODE_COUNT (NODE_COUNT),
    .ID_WIDTH   (ID_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .idle      (eng_idle),
    .rsp_valid (rsp_valid),
    .rsp_take  (rsp_take),
    .rsp       (rsp)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rsp_valid && rsp_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Load result fields
  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_take) begin
      status     <= rsp.status;
      found      <= rsp.found;
      match_id   <= rsp.match_id;
      next_state <= rsp.next_state;
      fail_state <= rsp.fail_state;
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the keyword trie automaton table.
`timescale 1ns / 100ps

module tb_top;
  import tkat_pkg::*;

  localparam int NODES     = 4096;
  localparam int IDLE_LIM  = 200000;
  localparam int N_RANDOM  = 1800;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key_byte;
    logic               last_byte;
    logic [KWID_W-1:0]  keyword_id;
    logic [STATE_W-1:0] state_in;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  found;
    logic [MATCH_ID_W-1:0] match_id;
    logic [STATE_W-1:0]    next_state;
    logic [STATE_W-1:0]    fail_state;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  logic [CMD_W-1:0] cmd = '0;
  logic [KEY_W-1:0] key_byte = '0;
  logic last_byte = 0;
  logic [KWID_W-1:0] keyword_id = '0;
  logic [STATE_W-1:0] state_in = '0;
  logic result_valid;
  logic result_stall = 1;
  logic [STATUS_W-1:0] status;
  logic found;
  logic [MATCH_ID_W-1:0] match_id;
  logic [STATE_W-1:0] next_state, fail_state;

  trie_keyword_automaton_table u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Trie mirror
  logic [7:0]  t_key   [NODES];
  int          t_first [NODES];
  int          t_next  [NODES];
  int          t_count [NODES];
  int          t_fail  [NODES];
  logic [16:0] t_pay   [NODES];
  int          t_used, ins_cur, srch_cur;
  bit          srch_miss, is_built;
  int          order [NODES];
  int          renum [NODES];

  item_t   pending_items[$];
  answer_t expected_answers[$];
  int      fail_count = 0;
  bit      stim_done = 0;
  bit      hold_long = 0;
  bit      no_idle = 0;
  int      idle_cycles = 0;

  function automatic void trie_clear();
    for (int i = 0; i < NODES; i++) begin
      t_key[i] = 0; t_first[i] = 0; t_next[i] = 0;
      t_count[i] = 0; t_fail[i] = 0; t_pay[i] = 0;
    end
    t_used = 1; ins_cur = 0; srch_cur = 0; srch_miss = 0; is_built = 0;
  endfunction

  // Walk a sorted sibling list; returns matching-or-next child and its predecessor
  function automatic int sibling_walk(int node, int k, output int prev);
    int c, guard;
    prev = 0; c = t_first[node]; guard = 0;
    while (c != 0 && guard < NODES && t_key[c] < k) begin
      prev = c; c = t_next[c]; guard++;
    end
    return c;
  endfunction

  function automatic int goto_search(int node, int k);
    int lo, hi, mid;
    if (t_count[node] == 0) return 0;
    lo = t_first[node];
    hi = lo + t_count[node];
    if (hi > NODES) hi = NODES;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (t_key[mid] == k) return mid;
      if (t_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return 0;
  endfunction

  function automatic void rebuild_bfs();
    int tail, c, f, m, guard;
    logic [7:0] nk [NODES];
    int nc [NODES];
    int ncount [NODES];
    logic [16:0] np [NODES];
    tail = 1; order[0] = 0;
    for (int h = 0; h < tail; h++) begin
      c = t_first[order[h]];
      while (c != 0 && tail < t_used) begin
        order[tail++] = c; c = t_next[c];
      end
    end
    for (int i = 0; i < NODES; i++) renum[i] = 0;
    for (int i = 0; i < tail; i++) renum[order[i]] = i;
    for (int i = 0; i < tail; i++) begin
      nk[i] = t_key[order[i]]; nc[i] = renum[t_first[order[i]]];
      ncount[i] = t_count[order[i]]; np[i] = t_pay[order[i]];
    end
    for (int i = 0; i < tail; i++) begin
      t_key[i] = nk[i]; t_first[i] = nc[i]; t_count[i] = ncount[i];
      t_pay[i] = np[i]; t_next[i] = 0; t_fail[i] = 0;
    end
    for (int i = 0; i < tail; i++)
      for (int j = 0; j < t_count[i] && t_first[i] + j < tail; j++)
        if (j + 1 < t_count[i]) t_next[t_first[i] + j] = t_first[i] + j + 1;
    for (int i = 1; i < tail; i++)
      for (int j = 0; j < t_count[i] && t_first[i] + j < tail; j++) begin
        f = t_fail[i];
        m = goto_search(f, t_key[t_first[i] + j]);
        guard = 0;
        while (f != 0 && m == 0 && guard < tail) begin
          f = t_fail[f]; m = goto_search(f, t_key[t_first[i] + j]); guard++;
        end
        t_fail[t_first[i] + j] = m;
      end
    ins_cur = 0; srch_cur = 0; srch_miss = 0; is_built = 1;
  endfunction

  // Predict one transaction and advance the mirror
  function automatic answer_t trie_predict(item_t it);
    answer_t a;
    int cur, c, prev, n, t;
    a = '0;
    case (it.cmd)
      CMD_INSERT: begin
        if (is_built) a.status = STATUS_PHASE;
        else begin
          cur = ins_cur;
          c = sibling_walk(cur, it.key_byte, prev);
          if (c != 0 && t_key[c] == it.key_byte) cur = c;
          else if (t_used >= NODES) begin
            a.status = STATUS_POOL_FULL; ins_cur = 0; cur = -1;
          end else begin
            n = t_used++;
            t_key[n] = it.key_byte; t_first[n] = 0; t_next[n] = c;
            t_fail[n] = 0; t_pay[n] = 0;
            if (prev == 0) t_first[cur] = n;
            else t_next[prev] = n;
            t_count[cur]++;
            cur = n;
          end
          if (cur >= 0) begin
            if (it.last_byte) begin
              t_pay[cur] = {1'b1, it.keyword_id}; ins_cur = 0;
            end else ins_cur = cur;
            a.match_id = t_pay[cur][15:0];
          end
        end
      end
      CMD_SEARCH: begin
        cur = srch_cur;
        if (!srch_miss) begin
          c = sibling_walk(cur, it.key_byte, prev);
          if (c != 0 && t_key[c] == it.key_byte) cur = c;
          else srch_miss = 1;
        end
        if (it.last_byte) begin
          if (!srch_miss && t_pay[cur][16]) begin
            a.found = 1; a.match_id = t_pay[cur][15:0];
          end else a.status = STATUS_NOT_FOUND;
          srch_cur = 0; srch_miss = 0;
        end else begin
          if (srch_miss) a.status = STATUS_NOT_FOUND;
          srch_cur = srch_miss ? 0 : cur;
        end
      end
      CMD_BUILD: rebuild_bfs();
      default: begin
        if (!is_built) a.status = STATUS_PHASE;
        else if (it.state_in >= t_used) a.status = STATUS_NOT_FOUND;
        else begin
          t = goto_search(it.state_in, it.key_byte);
          if (t == 0) a.status = STATUS_NOT_FOUND;
          else begin
            a.next_state = t; a.fail_state = t_fail[t];
            if (t_pay[t][16]) begin
              a.found = 1; a.match_id = t_pay[t][15:0];
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  function automatic item_t make_item(logic [1:0] c, int k, bit l, int id, int s);
    item_t it;
    it.cmd = c; it.key_byte = k; it.last_byte = l; it.keyword_id = id; it.state_in = s;
    return it;
  endfunction

  // Queue a keyword byte by byte from the first alpha lowercase letters, or any byte when alpha is 256
  task automatic push_word(logic [1:0] c, int len, int alpha);
    for (int i = 0; i < len; i++)
      pending_items.push_back(make_item(c, alpha == 256 ? $urandom_range(0, 255)
                                        : 8'h61 + $urandom_range(0, alpha - 1),
                                        i == len - 1, $urandom, $urandom));
  endtask

  task automatic push_steps(int cnt, int span);
    for (int i = 0; i < cnt; i++)
      pending_items.push_back(make_item(CMD_STEP, ($urandom_range(0, 3) == 0)
                              ? $urandom_range(0, 255) : 8'h61 + $urandom_range(0, 5),
                              $urandom_range(0, 1), $urandom,
                              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                              : $urandom_range(0, span)));
  endtask

  // Sender
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        void'(pending_items.pop_front());
        expected_answers.push_back(trie_predict({cmd, key_byte, last_byte,
                                                 keyword_id, state_in}));
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() > (item_valid && !item_stall ? 1 : 0) &&
            (no_idle || $urandom_range(0, 99) >= 30)) begin
          item_t nx;
          nx = pending_items[(item_valid && !item_stall) ? 1 : 0];
          item_valid <= 1;
          {cmd, key_byte, last_byte, keyword_id, state_in} <= nx;
        end else item_valid <= 0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        answer_t want;
        if (expected_answers.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (status !== want.status) begin
            $error("status exp %0d got %0d", want.status, status); fail_count++;
          end
          if (found !== want.found) begin
            $error("found exp %0d got %0d", want.found, found); fail_count++;
          end
          if (match_id !== want.match_id) begin
            $error("match_id exp %0h got %0h", want.match_id, match_id); fail_count++;
          end
          if (next_state !== want.next_state) begin
            $error("next_state exp %0d got %0d", want.next_state, next_state);
            fail_count++;
          end
          if (fail_state !== want.fail_state) begin
            $error("fail_state exp %0d got %0d", want.fail_state, fail_state);
            fail_count++;
          end
        end
      end
      result_stall <= hold_long || (!no_idle && $urandom_range(0, 99) < 30);
    end
  end

  // Watchdog on accepted transactions
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else if (stim_done && expected_answers.size() == 0)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIM) begin
      $display("trie_keyword_automaton_table test failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic drain();
    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  initial begin
    int span;
    trie_clear();
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: phase errors, field extremes, misses, build, steps
    pending_items.push_back(make_item(CMD_STEP, 8'h00, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'hFF, 1, 16'hFFFF, 12'hFFF));
    pending_items.push_back(make_item(CMD_INSERT, 8'h00, 0, 0, 0));
    pending_items.push_back(make_item(CMD_INSERT, 8'hFF, 1, 16'hFFFF, 12'hFFF));
    pending_items.push_back(make_item(CMD_INSERT, 8'h80, 1, 16'h5A5A, 0));
    pending_items.push_back(make_item(CMD_INSERT, 8'h00, 1, 16'h0001, 0));
    pending_items.push_back(make_item(CMD_INSERT, 8'h80, 0, 0, 0));
    pending_items.push_back(make_item(CMD_INSERT, 8'h00, 1, 16'hA5A5, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'h00, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'hFF, 1, 0, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'h80, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'h00, 1, 0, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'h11, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'h80, 1, 0, 0));
    pending_items.push_back(make_item(CMD_BUILD, 8'h00, 0, 0, 0));
    pending_items.push_back(make_item(CMD_INSERT, 8'h12, 1, 1, 0));
    for (int s = 0; s < 5; s++) begin
      pending_items.push_back(make_item(CMD_STEP, 8'h00, 0, 0, s));
      pending_items.push_back(make_item(CMD_STEP, 8'h80, 1, 0, s));
    end
    pending_items.push_back(make_item(CMD_STEP, 8'hFF, 0, 0, 12'hFFF));
    pending_items.push_back(make_item(CMD_SEARCH, 8'h80, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SEARCH, 8'h00, 1, 0, 0));
    drain();

    // Random: build keyword sets, build, then step and search; stretch without idling
    for (int r = 0; r < 6; r++) begin
      no_idle = (r == 2);
      repeat (40) push_word($urandom_range(0, 4) == 0 ? CMD_SEARCH : CMD_INSERT,
                            $urandom_range(1, 6), (r == 4) ? 256 : 4);
      pending_items.push_back(make_item(CMD_BUILD, $urandom, $urandom, $urandom, $urandom));
      span = 160;
      push_steps(60, span);
      repeat (10) push_word(CMD_SEARCH, $urandom_range(1, 5), 4);
      repeat (3) push_word(CMD_INSERT, 2, 4);
      if (r == 1) begin
        // Hold off the receiver while the sender keeps offering
        hold_long = 1;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      drain();
      trie_clear_dut_reset_free();
    end
    no_idle = 0;

    // Offer long random keywords (refused, as the trie is already built), then build and step
    repeat (600) push_word(CMD_INSERT, 8, 256);
    repeat (20) push_word(CMD_SEARCH, 3, 256);
    pending_items.push_back(make_item(CMD_BUILD, 0, 0, 0, 0));
    push_steps(150, 4095);
    pending_items.push_back(make_item(CMD_BUILD, 0, 0, 0, 0));
    push_steps(50, 4095);
    drain();

    stim_done = 1;
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && expected_answers.size() == 0)
      $display("trie_keyword_automaton_table test passed");
    else
      $display("trie_keyword_automaton_table test failed");
    $finish;
  end

  // The block has no way back to the insert phase, so later rounds work on the same built
  // trie and their inserts are refused with a phase error, unlike in the first round.
  task automatic trie_clear_dut_reset_free();
  endtask

endmodule
